// ----- rtl/core/prm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prm_pkg
// Shared types and codes for the pedigree relationship matrix block.
// ----------------------------------------------------------------------------
package prm_pkg;

    localparam int DEF_MAX_ANIMALS = 256;
    localparam int DEF_FRAC_BITS   = 30;

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_PARENT = 2'd2;
    localparam logic [1:0] STAT_RANGE  = 2'd3;

    typedef struct packed {
        logic       op;
        logic [8:0] sire;
        logic [8:0] dam;
        logic [7:0] row;
        logic [7:0] col;
    } prm_in_t;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  animal_index;
        logic [1:0]  status;
    } prm_out_t;

endpackage
`default_nettype wire

// ----- rtl/core/pedigree_relationship_matrix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pedigree_relationship_matrix
// Tabular-method numerator relationship matrix, lower triangle in one RAM.
// Add: SETUP, WALK (skipped for the first animal), DIAG_RD, DIAG_WR, DONE;
//      WALK visits each earlier animal in turn via both RAM read ports.
// Read: RD_ADDR, RD_WAIT, DONE. Rejected word (full/bad parent/range): DONE.
// Result becomes valid in the cycle the next word can be taken; the output
// register lets a new word enter while the result is still pending.
// Reset clears the animal count; RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
module pedigree_relationship_matrix
    import prm_pkg::*;
#(
    parameter int MAX_ANIMALS = DEF_MAX_ANIMALS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire prm_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output prm_out_t      m_data
);

    localparam int DEPTH  = MAX_ANIMALS * (MAX_ANIMALS + 1) / 2;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_ANIMALS);
    localparam int CNT_W  = $clog2(MAX_ANIMALS + 1);
    localparam int CMP_W  = (CNT_W > 9) ? CNT_W : 9;
    localparam int VAL_W  = FRAC_BITS + 2;
    localparam int PRD_W  = 2 * IDX_W + 1;
    localparam logic [VAL_W-1:0] FIX_ONE = VAL_W'(1) << FRAC_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RD_ADDR = 3'd1;
    localparam logic [2:0] ST_RD_WAIT = 3'd2;
    localparam logic [2:0] ST_SETUP   = 3'd3;
    localparam logic [2:0] ST_WALK    = 3'd4;
    localparam logic [2:0] ST_DIAG_RD = 3'd5;
    localparam logic [2:0] ST_DIAG_WR = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    // Lower triangle, entry (r,c) with r >= c at r*(r+1)/2 + c.
    logic [VAL_W-1:0] mem [DEPTH];

    logic [2:0]        state_reg;
    logic [CNT_W-1:0]  count_reg;       // animals added so far
    logic [ADDR_W-1:0] next_base_reg;   // row base of the next animal
    logic              sire_known_reg;
    logic              dam_known_reg;
    logic [IDX_W-1:0]  idx_a_reg;       // zero-based sire, or read row (max)
    logic [IDX_W-1:0]  idx_b_reg;       // zero-based dam, or read col (min)
    logic [ADDR_W-1:0] base_a_reg;
    logic [ADDR_W-1:0] base_b_reg;
    logic [IDX_W-1:0]  j_reg;           // walk column
    logic [ADDR_W-1:0] base_j_reg;      // row base of animal j
    logic              p1_valid_reg;    // walk write pending
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [VAL_W-1:0]  rd_a_reg;
    logic [VAL_W-1:0]  rd_b_reg;
    prm_out_t          res_reg;
    logic              m_valid_reg;
    prm_out_t          m_data_reg;

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W-1:0]  walk_val;
    logic [VAL_W-1:0]  diag_val;
    logic [PRD_W-1:0]  prod_a;
    logic [PRD_W-1:0]  prod_b;
    logic [ADDR_W-1:0] tri_base_a;
    logic [ADDR_W-1:0] tri_base_b;
    logic [CMP_W-1:0]  cnt_cmp;
    logic              accept;
    logic              out_free;
    logic              walk_last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_cmp  = CMP_W'(count_reg);
    assign walk_last = (j_reg == IDX_W'(count_reg - CNT_W'(1)));

    // p*(p+1)/2 row bases; idx_a is the read row in read mode
    assign prod_a     = PRD_W'(idx_a_reg) * (PRD_W'(idx_a_reg) + PRD_W'(1));
    assign prod_b     = PRD_W'(idx_b_reg) * (PRD_W'(idx_b_reg) + PRD_W'(1));
    assign tri_base_a = ADDR_W'(prod_a >> 1);
    assign tri_base_b = ADDR_W'(prod_b >> 1);

    // read address selection
    always_comb begin
        addr_a = '0;
        addr_b = '0;
        case (state_reg)
            ST_RD_ADDR: begin
                addr_a = tri_base_a + ADDR_W'(idx_b_reg);
            end
            ST_WALK: begin
                // entry (j, parent): mirrored when j is at or below the parent
                addr_a = (j_reg <= idx_a_reg) ? base_a_reg + ADDR_W'(j_reg)
                                              : base_j_reg + ADDR_W'(idx_a_reg);
                addr_b = (j_reg <= idx_b_reg) ? base_b_reg + ADDR_W'(j_reg)
                                              : base_j_reg + ADDR_W'(idx_b_reg);
            end
            ST_DIAG_RD: begin
                // sire-dam entry
                addr_a = (idx_a_reg <= idx_b_reg) ? base_b_reg + ADDR_W'(idx_a_reg)
                                                  : base_a_reg + ADDR_W'(idx_b_reg);
            end
            default: begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    // new row: floor((a+b)/2) if both parents known, half the known one, else 0
    always_comb begin
        if (sire_known_reg && dam_known_reg) begin
            walk_val = (rd_a_reg >> 1) + (rd_b_reg >> 1)
                     + (rd_a_reg & rd_b_reg & VAL_W'(1));
        end else if (sire_known_reg) begin
            walk_val = rd_a_reg >> 1;
        end else if (dam_known_reg) begin
            walk_val = rd_b_reg >> 1;
        end else begin
            walk_val = '0;
        end
    end

    assign diag_val = (sire_known_reg && dam_known_reg) ? FIX_ONE + (rd_a_reg >> 1)
                                                        : FIX_ONE;

    assign wr_en   = p1_valid_reg || (state_reg == ST_DIAG_WR);
    assign wr_addr = (state_reg == ST_DIAG_WR)
                   ? next_base_reg + ADDR_W'(count_reg) : p1_addr_reg;
    assign wr_data = (state_reg == ST_DIAG_WR) ? diag_val : walk_val;

    // store: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_reg.value <= '0;
                    if (s_data.op == OP_ADD) begin
                        sire_known_reg <= (s_data.sire != 9'd0);
                        dam_known_reg  <= (s_data.dam != 9'd0);
                        idx_a_reg <= (s_data.sire != 9'd0)
                                   ? IDX_W'(s_data.sire - 9'd1) : '0;
                        idx_b_reg <= (s_data.dam != 9'd0)
                                   ? IDX_W'(s_data.dam - 9'd1) : '0;
                        res_reg.animal_index <= '0;
                        if (count_reg == CNT_W'(MAX_ANIMALS)) begin
                            res_reg.status <= STAT_FULL;
                        end else if (CMP_W'(s_data.sire) > cnt_cmp
                                     || CMP_W'(s_data.dam) > cnt_cmp) begin
                            res_reg.status <= STAT_PARENT;
                        end else begin
                            res_reg.status <= STAT_OK;
                        end
                    end else begin
                        // keep the larger index as the row
                        if (s_data.row >= s_data.col) begin
                            idx_a_reg <= IDX_W'(s_data.row);
                            idx_b_reg <= IDX_W'(s_data.col);
                        end else begin
                            idx_a_reg <= IDX_W'(s_data.col);
                            idx_b_reg <= IDX_W'(s_data.row);
                        end
                        if (CMP_W'(s_data.row) >= cnt_cmp
                            || CMP_W'(s_data.col) >= cnt_cmp) begin
                            res_reg.status       <= STAT_RANGE;
                            res_reg.animal_index <= '0;
                        end else begin
                            res_reg.status       <= STAT_OK;
                            res_reg.animal_index <= s_data.row;
                        end
                    end
                end
            end
            ST_RD_WAIT: begin
                res_reg.value <= 32'(rd_a_reg);
            end
            ST_SETUP: begin
                base_a_reg <= tri_base_a;
                base_b_reg <= tri_base_b;
                j_reg      <= '0;
                base_j_reg <= '0;
            end
            ST_WALK: begin
                p1_addr_reg <= next_base_reg + ADDR_W'(j_reg);
                j_reg       <= j_reg + IDX_W'(1);
                base_j_reg  <= base_j_reg + ADDR_W'(j_reg) + ADDR_W'(1);
            end
            ST_DIAG_WR: begin
                res_reg.value        <= 32'(diag_val);
                res_reg.animal_index <= 8'(count_reg);
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            next_base_reg <= '0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            p1_valid_reg <= (state_reg == ST_WALK);
            // a finished word loads the output register, else a taken one leaves
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_data.op == OP_ADD) begin
                            if (count_reg == CNT_W'(MAX_ANIMALS)
                                || CMP_W'(s_data.sire) > cnt_cmp
                                || CMP_W'(s_data.dam) > cnt_cmp) begin
                                state_reg <= ST_DONE;
                            end else begin
                                state_reg <= ST_SETUP;
                            end
                        end else if (CMP_W'(s_data.row) >= cnt_cmp
                                     || CMP_W'(s_data.col) >= cnt_cmp) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_RD_ADDR;
                        end
                    end
                end
                ST_RD_ADDR: state_reg <= ST_RD_WAIT;
                ST_RD_WAIT: state_reg <= ST_DONE;
                ST_SETUP: begin
                    // first animal has no earlier row to fill
                    state_reg <= (count_reg == '0) ? ST_DIAG_RD : ST_WALK;
                end
                ST_WALK: begin
                    if (walk_last) begin
                        state_reg <= ST_DIAG_RD;
                    end
                end
                ST_DIAG_RD: state_reg <= ST_DIAG_WR;
                ST_DIAG_WR: begin
                    count_reg     <= count_reg + CNT_W'(1);
                    next_base_reg <= next_base_reg + ADDR_W'(count_reg) + ADDR_W'(1);
                    state_reg     <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= res_reg;
        end
    end

endmodule
`default_nettype wire

// ----- test/prm_checker.sv -----
// ----------------------------------------------------------------------------
// prm_checker
// Watches both channels of the relationship matrix block, keeps its own copy
// of the lower-triangle store, and compares each result word in order.
// ----------------------------------------------------------------------------
module prm_checker
    import prm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  prm_in_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  prm_out_t    m_data,
    output int unsigned outstanding,
    output int unsigned fail_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HERD_MAX = DEF_MAX_ANIMALS;
    localparam int unsigned SLOTS    = HERD_MAX * (HERD_MAX + 1) / 2;
    localparam logic [31:0] UNITY    = 32'd1 << DEF_FRAC_BITS;

    logic [31:0] kinship [SLOTS];
    int unsigned herd_size = 0;
    int unsigned fail_count = 0;
    prm_out_t    pending_q[$];

    assign fail_total = fail_count;

    function automatic int unsigned tri_slot(int unsigned r, int unsigned c);
        int unsigned t;
        if (r < c) begin
            t = r;
            r = c;
            c = t;
        end
        return r * (r + 1) / 2 + c;
    endfunction

    // floor((a+b)/2) without a carry out
    function automatic logic [31:0] halve_sum(logic [31:0] a, logic [31:0] b);
        return (a >> 1) + (b >> 1) + {31'd0, a[0] & b[0]};
    endfunction

    // applies one word to the shadow pedigree and returns the result word
    function automatic prm_out_t relationship_result(prm_in_t w);
        prm_out_t    r;
        int unsigned s;
        int unsigned d;
        int unsigned j;
        logic [31:0] v;
        r = '0;
        r.status = STAT_OK;
        s = w.sire;
        d = w.dam;
        if (w.op == OP_ADD) begin
            if (herd_size >= HERD_MAX) begin
                r.status = STAT_FULL;
            end else if (s > herd_size || d > herd_size) begin
                r.status = STAT_PARENT;
            end else begin
                for (j = 0; j < herd_size; j++) begin
                    if (s != 0 && d != 0)
                        v = halve_sum(kinship[tri_slot(j, s - 1)], kinship[tri_slot(j, d - 1)]);
                    else if (s != 0)
                        v = kinship[tri_slot(j, s - 1)] >> 1;
                    else if (d != 0)
                        v = kinship[tri_slot(j, d - 1)] >> 1;
                    else
                        v = '0;
                    kinship[tri_slot(herd_size, j)] = v;
                end
                if (s != 0 && d != 0)
                    r.value = UNITY + (kinship[tri_slot(s - 1, d - 1)] >> 1);
                else
                    r.value = UNITY;
                kinship[tri_slot(herd_size, herd_size)] = r.value;
                r.animal_index = herd_size[7:0];
                herd_size++;
            end
        end else begin
            if (w.row >= herd_size || w.col >= herd_size) begin
                r.status = STAT_RANGE;
            end else begin
                r.value = kinship[tri_slot(w.row, w.col)];
                r.animal_index = w.row;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        prm_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing pending: %h", m_data));
                end else begin
                    want = pending_q.pop_front();
                    if (m_data.value !== want.value)
                        report_mismatch($sformatf("value %h, predicted %h",
                                                  m_data.value, want.value));
                    if (m_data.animal_index !== want.animal_index)
                        report_mismatch($sformatf("animal_index %0d, predicted %0d",
                                                  m_data.animal_index, want.animal_index));
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_data.status, want.status));
                end
            end
            if (s_valid && s_ready)
                pending_q = {pending_q, relationship_result(s_data)};
        end
        outstanding <= pending_q.size();
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives add and read words into the relationship matrix block: a short
// hand-built pedigree first, then a random herd grown until the store is
// full, under changing idle and stall patterns. The checker decides.
// ----------------------------------------------------------------------------
module tb;
    import prm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HERD_MAX  = DEF_MAX_ANIMALS;
    localparam int unsigned N_RANDOM  = 530;
    localparam int unsigned HOLD_AT   = 250;   // lands in a no-idle stretch
    localparam int unsigned HOLD_LEN  = 600;   // cycles of receiver hold-off
    localparam int unsigned DRAIN_LEN = 300;   // longer than the longest add

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    prm_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    prm_out_t m_data;

    int unsigned outstanding;
    int unsigned fail_total;

    // idle and stall odds in percent, changed by the stimulus per phase
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    // long receiver hold-off, requested once by the stimulus
    logic        hold_req  = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_cnt  = 0;

    // animals the block should hold so far, for choosing legal parents
    int unsigned herd = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pedigree_relationship_matrix DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    prm_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .outstanding (outstanding),
        .fail_total  (fail_total)
    );

    // Receiver: random stalls, plus one long hold-off so the output register
    // fills and the block has to push back on its input.
    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt  <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic prm_in_t make_add(logic [8:0] sire, logic [8:0] dam);
        prm_in_t w;
        w      = '0;
        w.op   = OP_ADD;
        w.sire = sire;
        w.dam  = dam;
        w.row  = 8'($urandom);     // ignored on an add, but toggles anyway
        w.col  = 8'($urandom);
        return w;
    endfunction

    function automatic prm_in_t make_read(logic [7:0] row, logic [7:0] col);
        prm_in_t w;
        w      = '0;
        w.op   = OP_READ;
        w.row  = row;
        w.col  = col;
        w.sire = 9'($urandom_range(HERD_MAX));   // ignored on a read
        w.dam  = 9'($urandom_range(HERD_MAX));
        return w;
    endfunction

    // Parent choice: sometimes unknown, often a recent animal so that close
    // matings pile up inbreeding, otherwise anyone already in the herd.
    function automatic logic [8:0] pick_parent();
        int unsigned p;
        int unsigned span;
        if (herd == 0 || $urandom_range(9) == 0)
            return '0;
        if ($urandom_range(99) < 45) begin
            span = (herd < 8) ? herd : 8;
            p    = herd - $urandom_range(span - 1);
        end else begin
            p = $urandom_range(herd, 1);
        end
        return p[8:0];
    endfunction

    // Offers one word and returns at the edge that takes it. Valid is only
    // lowered when an idle gap is actually inserted.
    task automatic send_word(input prm_in_t w);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // a legal add grows the herd
        if (w.op == OP_ADD && herd < HERD_MAX && w.sire <= herd && w.dam <= herd)
            herd++;
    endtask

    initial begin
        int unsigned n;
        logic        want_add;
        logic [8:0]  sire;
        logic [8:0]  dam;
        logic [8:0]  tmp;
        logic [7:0]  row;
        logic [7:0]  col;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- hand-built pedigree, no idling ---
        send_word(make_read(8'd0, 8'd0));        // empty herd: out of range
        send_word(make_add(9'd1, 9'd0));         // sire not born yet
        send_word(make_add(9'd0, 9'd0));         // founder, animal 0
        send_word(make_add(9'd0, 9'd0));         // founder, animal 1
        send_word(make_add(9'd1, 9'd2));         // animal 2
        send_word(make_add(9'd1, 9'd2));         // animal 3, full sib of 2
        send_word(make_add(9'd3, 9'd4));         // full-sib mating
        send_word(make_add(9'd4, 9'd0));         // sire only
        send_word(make_add(9'd0, 9'd5));         // dam only
        send_word(make_add(9'd5, 9'd5));         // selfing, three generations
        send_word(make_add(9'd8, 9'd8));
        send_word(make_add(9'd9, 9'd9));
        send_word(make_add(9'd0, 9'd11));        // dam one past the herd
        send_word(make_add(9'd256, 9'd0));       // top sire index, not born
        send_word(make_read(8'd2, 8'd4));        // above diagonal: mirrored
        send_word(make_read(8'd4, 8'd2));
        send_word(make_read(8'd9, 8'd9));        // most inbred diagonal
        send_word(make_read(8'd10, 8'd0));       // row just past the herd
        send_word(make_read(8'd0, 8'd10));       // col just past the herd
        send_word(make_read(8'd255, 8'd255));
        send_word(make_read(8'd9, 8'd0));
        send_word(make_read(8'd0, 8'd0));
        send_word(make_add(9'd10, 9'd7));

        // --- random herd growth and reads ---
        for (n = 0; n < N_RANDOM; n++) begin
            // rotate the idle and stall pattern every 60 words
            case ((n / 60) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            if (n == HOLD_AT)
                hold_req <= 1'b1;

            // lean toward adds until the store is full, forced near the end
            if (herd < HERD_MAX)
                want_add = ($urandom_range(99) < 60) ||
                           (N_RANDOM - n < HERD_MAX - herd + 80);
            else
                want_add = ($urandom_range(99) < 20);

            if (want_add) begin
                if (herd < HERD_MAX && $urandom_range(99) < 8) begin
                    // one parent from the future
                    sire = 9'($urandom_range(HERD_MAX, herd + 1));
                    dam  = pick_parent();
                    if ($urandom_range(1)) begin
                        tmp  = sire;
                        sire = dam;
                        dam  = tmp;
                    end
                end else begin
                    sire = pick_parent();
                    dam  = ($urandom_range(99) < 6) ? sire : pick_parent();
                end
                send_word(make_add(sire, dam));
            end else begin
                if (herd == 0 || $urandom_range(99) < 15) begin
                    row = 8'($urandom_range(255));
                    col = 8'($urandom_range(255));
                    if (herd < HERD_MAX) begin
                        if ($urandom_range(1))
                            row = 8'($urandom_range(255, herd));
                        else
                            col = 8'($urandom_range(255, herd));
                    end
                end else begin
                    row = 8'($urandom_range(herd - 1));
                    col = 8'($urandom_range(herd - 1));
                end
                send_word(make_read(row, col));
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_LEN) @(posedge aclk);

        if (fail_total == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/prm_pkg.sv
rtl/core/pedigree_relationship_matrix.sv
test/prm_checker.sv
test/tb.sv
